// ===== design/lowpan_frame_fcs_filter_macros.svh =====
// Assertion macros shared by the frame filter RTL.
// Depends on nothing; included by modules that carry concurrent assertions.
`ifndef LOWPAN_FRAME_FCS_FILTER_MACROS_SVH
`define LOWPAN_FRAME_FCS_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LPFCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPFCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lpfcs_pkg.sv =====
// Types, constants and the CRC-16 byte step for the 802.15.4 frame FCS filter.
// Depends on nothing.
package lpfcs_pkg;

   localparam logic [1:0] ENCAP_RAW = 2'd0;
   localparam logic [1:0] ENCAP_ETH = 2'd1;
   localparam logic [1:0] ENCAP_SLL = 2'd2;

   localparam logic CSR_ENCAP_TYPE  = 1'b0;
   localparam logic CSR_FCS_PRESENT = 1'b1;

   localparam logic [15:0] HDR_LEN_RAW = 16'd0;
   localparam logic [15:0] HDR_LEN_ETH = 16'd14;
   localparam logic [15:0] HDR_LEN_SLL = 16'd16;

   localparam logic [15:0] ETH_TYPE_HI_POS = 16'd12;
   localparam logic [15:0] ETH_TYPE_LO_POS = 16'd13;
   localparam logic [15:0] SLL_TYPE_POS    = 16'd15;
   localparam logic [7:0]  ETH_TYPE_HI     = 8'h80;
   localparam logic [7:0]  ETH_TYPE_LO     = 8'h9a;
   localparam logic [7:0]  SLL_TYPE        = 8'hf6;

   localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
   localparam logic [15:0] CRC_INIT      = 16'h0000;
   localparam logic [15:0] COUNT_MAX     = 16'hffff;

   typedef enum logic [2:0] {
      DROP_NONE     = 3'd0,
      DROP_HDR_ONLY = 3'd1,
      DROP_SHORT    = 3'd2,
      DROP_FCS      = 3'd3,
      DROP_ENCAP    = 3'd4
   } drop_reason_type;

   typedef struct packed {
      logic [15:0]     payload_length;
      drop_reason_type drop_reason;
      logic            frame_pass;
   } verdict_type;

   // One byte of the reflected CRC-16 (KERMIT polynomial), LSB first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== design/lowpan_frame_fcs_filter.sv =====
// Top level of the 802.15.4 capture frame filter with CRC-16 FCS check.
// Depends on lpfcs_pkg and lowpan_frame_fcs_filter_macros.svh.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_tvalid / req_tready | byte, tlast = last byte, tuser = truncated
//   rsp     | out       | rsp_tvalid / rsp_tready | pass flag, drop reason, payload length
//   csr     | in        | csr_valid / csr_ready   | register index, write data
//
// One byte is taken per clock while no last byte waits on a stalled result. A byte
// is held in the input register, then the CRC step and the verdict logic update the
// frame state and, on the last byte, load the result register: the verdict is
// registered on the edge on which its last byte leaves the input register. Reset is
// synchronous, clears the frame state and the valid flags, and sets the configuration to raw with an FCS present.
// A stalled result holds only last bytes back; other bytes keep flowing.
`include "lowpan_frame_fcs_filter_macros.svh"

module lowpan_frame_fcs_filter
   import lpfcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic [0:0]  req_tuser,   // [0] truncated
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] frame_pass, [3:1] drop_reason,
                                    // [19:4] payload_length, [23:20] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [1:0]  csr_wdata
);

   logic [1:0]  encap_type_ff;
   logic        fcs_present_ff;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        in_trunc_ff;

   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  tail0_ff, tail0_in;
   logic [7:0]  tail1_ff, tail1_in;
   logic        encap_match_ff, encap_match_in;

   logic        rsp_valid_ff;
   verdict_type verdict_ff, verdict_in;

   logic        advance;
   logic [15:0] hdr_len;
   logic [15:0] total;
   logic [15:0] plen;
   drop_reason_type reason;

   // A byte moves on unless it is a last byte facing a full, stalled result.
   assign advance    = in_valid_ff & (~in_last_ff | ~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, verdict_ff};

   always_comb begin
      unique case (encap_type_ff)
         ENCAP_ETH: hdr_len = HDR_LEN_ETH;
         ENCAP_SLL: hdr_len = HDR_LEN_SLL;
         default:   hdr_len = HDR_LEN_RAW;
      endcase

      encap_match_in = encap_match_ff;
      if (encap_type_ff == ENCAP_ETH) begin
         if (byte_count_ff == ETH_TYPE_HI_POS && in_byte_ff != ETH_TYPE_HI) begin
            encap_match_in = 1'b0;
         end
         if (byte_count_ff == ETH_TYPE_LO_POS && in_byte_ff != ETH_TYPE_LO) begin
            encap_match_in = 1'b0;
         end
      end else if (encap_type_ff == ENCAP_SLL) begin
         if (byte_count_ff == SLL_TYPE_POS && in_byte_ff != SLL_TYPE) begin
            encap_match_in = 1'b0;
         end
      end

      // Body bytes pass through a two-byte delay so the FCS never enters the CRC.
      crc_in   = crc_ff;
      tail0_in = tail0_ff;
      tail1_in = tail1_ff;
      if (byte_count_ff >= hdr_len) begin
         if (byte_count_ff >= hdr_len + 16'd2) begin
            crc_in = crc16_byte(crc_ff, tail0_ff);
         end
         tail0_in = tail1_ff;
         tail1_in = in_byte_ff;
      end

      total = (byte_count_ff == COUNT_MAX) ? COUNT_MAX : byte_count_ff + 16'd1;
      byte_count_in = total;

      reason = DROP_NONE;
      plen   = 16'd0;
      if (total <= hdr_len) begin
         reason = DROP_HDR_ONLY;
      end else if (fcs_present_ff && total <= hdr_len + 16'd2) begin
         reason = DROP_SHORT;
      end else begin
         plen = total - hdr_len;
         if (fcs_present_ff && !in_trunc_ff) begin
            plen = plen - 16'd2;
            if ({tail1_in, tail0_in} != crc_in) begin
               reason = DROP_FCS;
            end
         end
         if (reason == DROP_NONE && !encap_match_in) begin
            reason = DROP_ENCAP;
         end
      end

      verdict_in.frame_pass     = (reason == DROP_NONE);
      verdict_in.drop_reason    = reason;
      verdict_in.payload_length = (reason == DROP_NONE) ? plen : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         encap_type_ff  <= ENCAP_RAW;
         fcs_present_ff <= 1'b1;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         byte_count_ff  <= 16'd0;
         crc_ff         <= CRC_INIT;
         tail0_ff       <= 8'h00;
         tail1_ff       <= 8'h00;
         encap_match_ff <= 1'b1;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ENCAP_TYPE:  encap_type_ff  <= csr_wdata;
               CSR_FCS_PRESENT: fcs_present_ff <= csr_wdata[0];
               default:         ;
            endcase
         end

         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end

         if (advance && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (advance) begin
            if (in_last_ff) begin
               byte_count_ff  <= 16'd0;
               crc_ff         <= CRC_INIT;
               tail0_ff       <= 8'h00;
               tail1_ff       <= 8'h00;
               encap_match_ff <= 1'b1;
            end else begin
               byte_count_ff  <= byte_count_in;
               crc_ff         <= crc_in;
               tail0_ff       <= tail0_in;
               tail1_ff       <= tail1_in;
               encap_match_ff <= encap_match_in;
            end
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_last_ff  <= req_tlast;
         in_trunc_ff <= req_tuser[0];
      end
      if (advance && in_last_ff) begin
         verdict_ff <= verdict_in;
      end
   end

   `LPFCS_ASSERT_NEXT(a_last_gives_result, clock, reset, advance && in_last_ff,
      rsp_valid_ff, "last byte produced no result")
   `LPFCS_ASSERT_NEXT(a_frame_state_cleared, clock, reset, advance && in_last_ff,
      byte_count_ff == 16'd0 && crc_ff == CRC_INIT && encap_match_ff,
      "frame state not cleared after last byte")
   `LPFCS_ASSERT_NOW(a_drop_has_no_length, clock, reset,
      rsp_valid_ff && verdict_ff.drop_reason != DROP_NONE,
      verdict_ff.payload_length == 16'd0 && !verdict_ff.frame_pass,
      "dropped frame reports a length or a pass")
   `LPFCS_ASSERT_NOW(a_stall_needs_item, clock, reset, !req_tready,
      in_valid_ff && in_last_ff && rsp_valid_ff, "input stalled without a waiting last byte")

endmodule
